### rtl/fully_associative_lru_tlb_unit_macros.svh
// Assertion macros for the fully associative LRU TLB unit.
// Included by the top level; SYNTH turns every check into an empty line.
`ifndef FULLY_ASSOCIATIVE_LRU_TLB_UNIT_MACROS_SVH
`define FULLY_ASSOCIATIVE_LRU_TLB_UNIT_MACROS_SVH
`ifndef SYNTH
// Same-cycle implication, checked out of reset.
`define FATLB_ASSERT_NOW(lbl, clk_s, rstn_s, ante, cons) \
  lbl: assert property (@(posedge clk_s) disable iff (!rstn_s) (ante) |-> (cons)) \
    else $error("assertion failed: %m");
// Next-cycle implication, checked out of reset.
`define FATLB_ASSERT_NEXT(lbl, clk_s, rstn_s, ante, cons) \
  lbl: assert property (@(posedge clk_s) disable iff (!rstn_s) (ante) |=> (cons)) \
    else $error("assertion failed: %m");
`else
`define FATLB_ASSERT_NOW(lbl, clk_s, rstn_s, ante, cons)
`define FATLB_ASSERT_NEXT(lbl, clk_s, rstn_s, ante, cons)
`endif
`endif

### rtl/fatlb_pkg.sv
// Shared types and constants of the fully associative LRU TLB unit.
// No dependencies; every other file of the block but the macro header uses it.
package fatlb_pkg;

  localparam int PAGE_W     = 52;
  localparam int ASID_W     = 16;
  localparam int CNT_W      = 32;
  localparam int OP_W       = 2;
  localparam int CFG_ADDR_W = 2;
  localparam int CFG_DATA_W = 16;

  // Operation codes; code 3 is undefined and leaves table and counters unchanged
  typedef enum logic [OP_W-1:0] {
    OP_LOOKUP = 2'd0,
    OP_ADD    = 2'd1,
    OP_FLUSH  = 2'd2
  } op_t;

  // Configuration register indexes
  localparam logic [CFG_ADDR_W-1:0] CFG_ASID_EN  = 2'd0;
  localparam logic [CFG_ADDR_W-1:0] CFG_CUR_ASID = 2'd1;

  // Controller states
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_COMMIT
  } state_t;

  // Controller to datapath
  typedef struct packed {
    logic load;    // capture the accepted item, restart the scan
    logic scan;    // walk one entry per cycle
    logic commit;  // apply the update and load the result register
  } ctrl_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic scan_done;
  } dp_stat_t;

endpackage

### rtl/fatlb_in_if.sv
// Input channel of the TLB unit: one operation per transfer.
// Depends on fatlb_pkg for field widths.
interface fatlb_in_if;
  logic                           valid;
  logic                           ready;
  logic [fatlb_pkg::OP_W-1:0]     operation;
  logic [fatlb_pkg::PAGE_W-1:0]   virtual_page;
  logic [fatlb_pkg::PAGE_W-1:0]   physical_page;

  modport source (output valid, output operation, output virtual_page,
                  output physical_page, input ready);
  modport sink   (input valid, input operation, input virtual_page,
                  input physical_page, output ready);
endinterface

### rtl/fatlb_out_if.sv
// Result channel of the TLB unit: one result per operation.
// Depends on fatlb_pkg for field widths.
interface fatlb_out_if;
  logic                          valid;
  logic                          ready;
  logic                          hit;
  logic [fatlb_pkg::PAGE_W-1:0]  found_page;
  logic                          evicted;
  logic [fatlb_pkg::CNT_W-1:0]   lookup_count;
  logic [fatlb_pkg::CNT_W-1:0]   hit_count;
  logic [fatlb_pkg::CNT_W-1:0]   add_eviction_count;
  logic [fatlb_pkg::CNT_W-1:0]   flush_count;
  logic [fatlb_pkg::CNT_W-1:0]   flush_eviction_count;

  modport source (output valid, output hit, output found_page, output evicted,
                  output lookup_count, output hit_count, output add_eviction_count,
                  output flush_count, output flush_eviction_count, input ready);
  modport sink   (input valid, input hit, input found_page, input evicted,
                  input lookup_count, input hit_count, input add_eviction_count,
                  input flush_count, input flush_eviction_count, output ready);
endinterface

### rtl/fatlb_cfg_if.sv
// Configuration write channel of the TLB unit: register index and data.
// Depends on fatlb_pkg for field widths.
interface fatlb_cfg_if;
  logic                              valid;
  logic                              ready;
  logic [fatlb_pkg::CFG_ADDR_W-1:0]  addr;
  logic [fatlb_pkg::CFG_DATA_W-1:0]  data;

  modport source (output valid, output addr, output data, input ready);
  modport sink   (input valid, input addr, input data, output ready);
endinterface

### rtl/fatlb_ctrl.sv
// Controller of the TLB unit: sequences load, scan and commit, owns both handshakes.
// Depends on fatlb_pkg.
module fatlb_ctrl (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  input  logic [fatlb_pkg::OP_W-1:0]  in_op,
  output logic                        in_ready,
  output logic                        out_valid,
  input  logic                        out_ready,
  input  fatlb_pkg::dp_stat_t         stat,
  output fatlb_pkg::ctrl_cmd_t        cmd
);

  fatlb_pkg::state_t state_r, state_nxt;
  logic              out_valid_r, out_valid_nxt;
  logic              needs_scan;

  // Lookups and adds walk the table; flush and the undefined code do not
  assign needs_scan = (in_op == fatlb_pkg::OP_LOOKUP) || (in_op == fatlb_pkg::OP_ADD);

  // State register and result-valid flag
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= fatlb_pkg::ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Next state and commands
  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_ready  = 1'b0;
    case (state_r)
      fatlb_pkg::ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = needs_scan ? fatlb_pkg::ST_SCAN : fatlb_pkg::ST_COMMIT;
        end
      end
      fatlb_pkg::ST_SCAN: begin
        cmd.scan = 1'b1;
        if (stat.scan_done) begin
          state_nxt = fatlb_pkg::ST_COMMIT;
        end
      end
      fatlb_pkg::ST_COMMIT: begin
        // hold until the result register is free or being emptied
        if (!out_valid_r || out_ready) begin
          cmd.commit = 1'b1;
          state_nxt  = fatlb_pkg::ST_IDLE;
        end
      end
      default: begin
        state_nxt = fatlb_pkg::ST_IDLE;
      end
    endcase

    if (cmd.commit) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  assign out_valid = out_valid_r;

endmodule

### rtl/fatlb_dp.sv
// Datapath of the TLB unit: entry memory, rank and valid flops, scan trackers,
// statistics counters, configuration and result registers. Depends on fatlb_pkg.
module fatlb_dp #(
  parameter int ENTRIES = 16
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  fatlb_pkg::ctrl_cmd_t              cmd,
  output fatlb_pkg::dp_stat_t               stat,
  input  logic [fatlb_pkg::OP_W-1:0]        in_op,
  input  logic [fatlb_pkg::PAGE_W-1:0]      in_vpage,
  input  logic [fatlb_pkg::PAGE_W-1:0]      in_ppage,
  input  logic                              cfg_we,
  input  logic [fatlb_pkg::CFG_ADDR_W-1:0]  cfg_addr,
  input  logic [fatlb_pkg::CFG_DATA_W-1:0]  cfg_data,
  output logic                              hit,
  output logic [fatlb_pkg::PAGE_W-1:0]      found_page,
  output logic                              evicted,
  output logic [fatlb_pkg::CNT_W-1:0]       lookup_count,
  output logic [fatlb_pkg::CNT_W-1:0]       hit_count,
  output logic [fatlb_pkg::CNT_W-1:0]       add_eviction_count,
  output logic [fatlb_pkg::CNT_W-1:0]       flush_count,
  output logic [fatlb_pkg::CNT_W-1:0]       flush_eviction_count
);

  localparam int IW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int CW = $clog2(ENTRIES + 1);
  localparam int RW = IW;
  localparam logic [CW-1:0] FULL_CNT = CW'(ENTRIES);
  localparam logic [RW-1:0] LRU_RANK = RW'(ENTRIES - 1);

  typedef struct packed {
    logic [fatlb_pkg::PAGE_W-1:0] vpage;
    logic [fatlb_pkg::PAGE_W-1:0] ppage;
    logic [fatlb_pkg::ASID_W-1:0] asid;
  } entry_t;

  // Captured item
  logic [fatlb_pkg::OP_W-1:0]   op_r;
  logic [fatlb_pkg::PAGE_W-1:0] vp_r, pp_r;

  // Configuration
  logic                         asid_en_r;
  logic [fatlb_pkg::ASID_W-1:0] cur_asid_r;

  // Table state
  entry_t          mem [ENTRIES];
  entry_t          rd_ent_r;
  logic            valid_r   [ENTRIES];
  logic            valid_nxt [ENTRIES];
  logic [RW-1:0]   rank_r    [ENTRIES];
  logic [RW-1:0]   rank_nxt  [ENTRIES];
  logic [CW-1:0]   occ_r, occ_nxt;

  // Scan pipeline and trackers
  logic [CW-1:0]   rd_idx_r, rd_idx_nxt;
  logic            eval_v_r, eval_v_nxt;
  logic [IW-1:0]   eval_idx_r;
  logic            rd_valid_r;
  logic [RW-1:0]   rd_rank_r;
  logic            best_found_r, best_found_nxt;
  logic [IW-1:0]   best_idx_r;
  logic [RW-1:0]   best_rank_r;
  logic [fatlb_pkg::PAGE_W-1:0] best_pp_r;
  logic            slot_found_r, slot_found_nxt;
  logic [IW-1:0]   slot_idx_r;
  logic [IW-1:0]   victim_idx_r;

  // Counters and result
  logic [fatlb_pkg::CNT_W-1:0]  lookup_cnt_r, lookup_cnt_nxt;
  logic [fatlb_pkg::CNT_W-1:0]  hit_cnt_r, hit_cnt_nxt;
  logic [fatlb_pkg::CNT_W-1:0]  evict_cnt_r, evict_cnt_nxt;
  logic [fatlb_pkg::CNT_W-1:0]  flush_cnt_r, flush_cnt_nxt;
  logic [fatlb_pkg::CNT_W-1:0]  flush_ev_cnt_r, flush_ev_cnt_nxt;
  logic                         hit_r, hit_nxt;
  logic [fatlb_pkg::PAGE_W-1:0] found_r, found_nxt;
  logic                         evicted_r, evicted_nxt;

  logic            scan_rd, match, better, new_slot, is_lru, full, mem_we;
  logic [IW-1:0]   ins_idx;

  // Scan: one entry read per cycle, evaluated in the following cycle
  assign scan_rd  = cmd.scan && (rd_idx_r != FULL_CNT);
  assign match    = eval_v_r && rd_valid_r && (rd_ent_r.vpage == vp_r) &&
                    (!asid_en_r || (rd_ent_r.asid == cur_asid_r));
  assign better   = match && (!best_found_r || (rd_rank_r < best_rank_r));
  assign new_slot = eval_v_r && !rd_valid_r && !slot_found_r;
  assign is_lru   = eval_v_r && rd_valid_r && (rd_rank_r == LRU_RANK);
  assign full     = (occ_r == FULL_CNT);
  // when full, the victim's slot is the first free one after eviction
  assign ins_idx  = full ? victim_idx_r : slot_idx_r;

  assign stat.scan_done = (rd_idx_r == FULL_CNT) && !eval_v_r;

  always_comb begin
    rd_idx_nxt     = cmd.load ? '0 : (scan_rd ? rd_idx_r + 1'b1 : rd_idx_r);
    eval_v_nxt     = scan_rd;
    best_found_nxt = !cmd.load && (best_found_r || better);
    slot_found_nxt = !cmd.load && (slot_found_r || new_slot);
  end

  // Commit: rank, valid, occupancy, counters and result
  always_comb begin
    valid_nxt        = valid_r;
    rank_nxt         = rank_r;
    occ_nxt          = occ_r;
    lookup_cnt_nxt   = lookup_cnt_r;
    hit_cnt_nxt      = hit_cnt_r;
    evict_cnt_nxt    = evict_cnt_r;
    flush_cnt_nxt    = flush_cnt_r;
    flush_ev_cnt_nxt = flush_ev_cnt_r;
    hit_nxt          = 1'b0;
    found_nxt        = '0;
    evicted_nxt      = 1'b0;
    mem_we           = 1'b0;
    if (cmd.commit) begin
      case (op_r)
        fatlb_pkg::OP_LOOKUP: begin
          lookup_cnt_nxt = lookup_cnt_r + 1'b1;
          if (best_found_r) begin
            hit_cnt_nxt = hit_cnt_r + 1'b1;
            hit_nxt     = 1'b1;
            found_nxt   = best_pp_r;
            // entries more recent than the hit age by one
            for (int i = 0; i < ENTRIES; i++) begin
              if (valid_r[i] && (rank_r[i] < best_rank_r)) begin
                rank_nxt[i] = rank_r[i] + 1'b1;
              end
            end
            rank_nxt[best_idx_r] = '0;
          end
        end
        fatlb_pkg::OP_ADD: begin
          mem_we = 1'b1;
          if (full) begin
            evict_cnt_nxt = evict_cnt_r + 1'b1;
            evicted_nxt   = 1'b1;
          end else begin
            occ_nxt = occ_r + 1'b1;
          end
          // every surviving entry ages by one
          for (int i = 0; i < ENTRIES; i++) begin
            if (valid_r[i] && !(full && (IW'(i) == victim_idx_r))) begin
              rank_nxt[i] = rank_r[i] + 1'b1;
            end
          end
          valid_nxt[ins_idx] = 1'b1;
          rank_nxt[ins_idx]  = '0;
        end
        fatlb_pkg::OP_FLUSH: begin
          flush_cnt_nxt    = flush_cnt_r + 1'b1;
          flush_ev_cnt_nxt = flush_ev_cnt_r + fatlb_pkg::CNT_W'(occ_r);
          for (int i = 0; i < ENTRIES; i++) begin
            valid_nxt[i] = 1'b0;
            rank_nxt[i]  = '0;
          end
          occ_nxt = '0;
        end
        default: begin
        end
      endcase
    end
  end

  // Control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      asid_en_r      <= 1'b0;
      cur_asid_r     <= '0;
      occ_r          <= '0;
      rd_idx_r       <= '0;
      eval_v_r       <= 1'b0;
      best_found_r   <= 1'b0;
      slot_found_r   <= 1'b0;
      lookup_cnt_r   <= '0;
      hit_cnt_r      <= '0;
      evict_cnt_r    <= '0;
      flush_cnt_r    <= '0;
      flush_ev_cnt_r <= '0;
      for (int i = 0; i < ENTRIES; i++) begin
        valid_r[i] <= 1'b0;
        rank_r[i]  <= '0;
      end
    end else begin
      if (cfg_we) begin
        case (cfg_addr)
          fatlb_pkg::CFG_ASID_EN:  asid_en_r  <= cfg_data[0];
          fatlb_pkg::CFG_CUR_ASID: cur_asid_r <= cfg_data[fatlb_pkg::ASID_W-1:0];
          default: begin
          end
        endcase
      end
      occ_r          <= occ_nxt;
      rd_idx_r       <= rd_idx_nxt;
      eval_v_r       <= eval_v_nxt;
      best_found_r   <= best_found_nxt;
      slot_found_r   <= slot_found_nxt;
      lookup_cnt_r   <= lookup_cnt_nxt;
      hit_cnt_r      <= hit_cnt_nxt;
      evict_cnt_r    <= evict_cnt_nxt;
      flush_cnt_r    <= flush_cnt_nxt;
      flush_ev_cnt_r <= flush_ev_cnt_nxt;
      valid_r        <= valid_nxt;
      rank_r         <= rank_nxt;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op_r <= in_op;
      vp_r <= in_vpage;
      pp_r <= in_ppage;
    end
    if (scan_rd) begin
      eval_idx_r <= rd_idx_r[IW-1:0];
      rd_valid_r <= valid_r[rd_idx_r[IW-1:0]];
      rd_rank_r  <= rank_r[rd_idx_r[IW-1:0]];
    end
    if (better) begin
      best_idx_r  <= eval_idx_r;
      best_rank_r <= rd_rank_r;
      best_pp_r   <= rd_ent_r.ppage;
    end
    if (new_slot) begin
      slot_idx_r <= eval_idx_r;
    end
    if (is_lru) begin
      victim_idx_r <= eval_idx_r;
    end
    if (cmd.commit) begin
      hit_r     <= hit_nxt;
      found_r   <= found_nxt;
      evicted_r <= evicted_nxt;
    end
  end

  // Entry memory: one write port, one registered read port
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[ins_idx] <= '{vpage: vp_r, ppage: pp_r, asid: cur_asid_r};
    end
    if (scan_rd) begin
      rd_ent_r <= mem[rd_idx_r[IW-1:0]];
    end
  end

  // Counters stay put while a result waits, so they feed the port directly
  assign hit                  = hit_r;
  assign found_page           = found_r;
  assign evicted              = evicted_r;
  assign lookup_count         = lookup_cnt_r;
  assign hit_count            = hit_cnt_r;
  assign add_eviction_count   = evict_cnt_r;
  assign flush_count          = flush_cnt_r;
  assign flush_eviction_count = flush_ev_cnt_r;

endmodule

### rtl/fully_associative_lru_tlb_unit.sv
// Top level of the fully associative LRU TLB unit: controller plus datapath.
// Depends on fatlb_pkg, the three channel interfaces, fatlb_ctrl, fatlb_dp
// and the assertion macro header.
//
//   channel   direction  carries
//   in_if     sink       operation, virtual_page, physical_page
//   out_if    source     hit, found_page, evicted, five statistics counters
//   cfg_if    sink       addr (0 asid_enable, 1 current_asid), data
//
// A lookup or add is accepted, walks the table one entry per cycle through the
// entry memory's read port, then commits; the next item is taken only after that.
// A flush or an undefined operation skips the walk and goes straight to commit.
// Reset (rst_n low, synchronous) empties the table and clears counters and config.
// A result waits in its register while the next item is accepted; a stalled
// output only holds the commit step. Configuration writes are always taken.
`include "fully_associative_lru_tlb_unit_macros.svh"

module fully_associative_lru_tlb_unit #(
  parameter int ENTRIES = 16
) (
  input  logic         clk,
  input  logic         rst_n,
  fatlb_in_if.sink     in_if,
  fatlb_out_if.source  out_if,
  fatlb_cfg_if.sink    cfg_if
);

  fatlb_pkg::ctrl_cmd_t cmd;
  fatlb_pkg::dp_stat_t  stat;

  // Configuration transfers are accepted every cycle
  assign cfg_if.ready = 1'b1;

  // Sequencer
  fatlb_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_if.valid),
    .in_op     (in_if.operation),
    .in_ready  (in_if.ready),
    .out_valid (out_if.valid),
    .out_ready (out_if.ready),
    .stat      (stat),
    .cmd       (cmd)
  );

  // Table, counters and result
  fatlb_dp #(
    .ENTRIES (ENTRIES)
  ) u_dp (
    .clk                  (clk),
    .rst_n                (rst_n),
    .cmd                  (cmd),
    .stat                 (stat),
    .in_op                (in_if.operation),
    .in_vpage             (in_if.virtual_page),
    .in_ppage             (in_if.physical_page),
    .cfg_we               (cfg_if.valid),
    .cfg_addr             (cfg_if.addr),
    .cfg_data             (cfg_if.data),
    .hit                  (out_if.hit),
    .found_page           (out_if.found_page),
    .evicted              (out_if.evicted),
    .lookup_count         (out_if.lookup_count),
    .hit_count            (out_if.hit_count),
    .add_eviction_count   (out_if.add_eviction_count),
    .flush_count          (out_if.flush_count),
    .flush_eviction_count (out_if.flush_eviction_count)
  );

  // Checks
  `FATLB_ASSERT_NEXT(a_accept_then_busy, clk, rst_n, in_if.valid && in_if.ready, !in_if.ready)
  `FATLB_ASSERT_NOW(a_result_after_commit, clk, rst_n, $rose(out_if.valid), $past(cmd.commit))
  `FATLB_ASSERT_NOW(a_miss_page_zero, clk, rst_n, out_if.valid && !out_if.hit, out_if.found_page == '0)
  `FATLB_ASSERT_NOW(a_hit_evict_excl, clk, rst_n, out_if.valid, !(out_if.hit && out_if.evicted))

endmodule
